### rtl/mrt_pkg.sv
// Shared types, widths and status codes for the mapped region table.
// No dependencies; every other file uses this package.
package mrt_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int OPEN_FILES_DEF  = 16;

  localparam int ADDR_W  = 38;
  localparam int START_W = 39;
  localparam int LEN_W   = 32;
  localparam int SLEN_W  = 31;
  localparam int OFS_W   = 32;
  localparam int PID_W   = 6;
  localparam int FD_W    = 6;
  localparam int STAT_W  = 4;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;

  localparam logic [1:0] ACT_MAP     = 2'd0;
  localparam logic [1:0] ACT_UNMAP   = 2'd1;
  localparam logic [1:0] ACT_FAULT   = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 4'd0;
  localparam logic [STAT_W-1:0] ST_MISALIGNED = 4'd1;
  localparam logic [STAT_W-1:0] ST_BAD_LENGTH = 4'd2;
  localparam logic [STAT_W-1:0] ST_BAD_PROT   = 4'd3;
  localparam logic [STAT_W-1:0] ST_BAD_FLAGS  = 4'd4;
  localparam logic [STAT_W-1:0] ST_BAD_FILE   = 4'd5;
  localparam logic [STAT_W-1:0] ST_FULL       = 4'd6;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 4'd7;
  localparam logic [STAT_W-1:0] ST_DENIED     = 4'd8;

  localparam logic [ADDR_W-1:0] MAP_BASE_RST = 38'd1073741824;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SLEN_W-1:0]  length;
    logic [OFS_W-1:0]   src_offset;
    logic               writable;
    logic               anonymous;
  } mrt_entry_t;

  typedef struct packed {
    logic               en;
    logic               data_en;
    logic [PID_W-1:0]   owner;
    mrt_entry_t         entry;
  } mrt_wr_t;

endpackage

### rtl/mrt_if.sv
// Request and response channel interfaces with valid/ready handshake.
// Depends on mrt_pkg for field widths.
interface mrt_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [mrt_pkg::PID_W-1:0]      process_id;
  logic [mrt_pkg::ADDR_W-1:0]     address;
  logic signed [mrt_pkg::LEN_W-1:0] length;
  logic [1:0]                     prot;
  logic [1:0]                     flags;
  logic signed [mrt_pkg::FD_W-1:0] fd;
  logic signed [mrt_pkg::OFS_W-1:0] src_offset;
  logic [2:0]                     file_access;
  logic                           store_fault;

  modport source (output valid, action, process_id, address, length, prot, flags, fd,
                  src_offset, file_access, store_fault, input ready);
  modport sink (input valid, action, process_id, address, length, prot, flags, fd,
                src_offset, file_access, store_fault, output ready);
endinterface

interface mrt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mrt_pkg::STAT_W-1:0]     status;
  logic [mrt_pkg::START_W-1:0]    region_address;
  logic [mrt_pkg::SLOT_W-1:0]     slot;
  logic [mrt_pkg::OFS_W-1:0]      page_file_offset;
  logic                           is_anonymous;
  logic                           is_writable;
  logic [mrt_pkg::CNT_W-1:0]      removed_count;

  modport source (output valid, status, region_address, slot, page_file_offset,
                  is_anonymous, is_writable, removed_count, input ready);
  modport sink (input valid, status, region_address, slot, page_file_offset,
                is_anonymous, is_writable, removed_count, output ready);
endinterface

### rtl/mmap_region_table.sv
// Mapped region table top level: request decode, slot scan sequencer, result register.
// A rejected map or a misaligned unmap goes straight to the result register with no
// scan; otherwise a scan of up to TABLE_SLOTS slots, one read per cycle, comes first.
// One request at a time is taken, and the scan goes through the single read port of
// the slot memory. Reset (rst, synchronous) frees all slots
// at once and loads map_base with 0x40000000.
module mmap_region_table #(
  parameter int TABLE_SLOTS = mrt_pkg::TABLE_SLOTS_DEF,
  parameter int PAGE_BYTES  = mrt_pkg::PAGE_BYTES_DEF,
  parameter int OPEN_FILES  = mrt_pkg::OPEN_FILES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [mrt_pkg::ADDR_W-1:0] cfg_wr_data,
  mrt_req_if.sink                    req,
  mrt_rsp_if.source                  rsp
);
  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PB = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state;
  logic [mrt_pkg::ADDR_W-1:0]  map_base;
  logic [1:0]                  act;
  logic [mrt_pkg::PID_W-1:0]   pid;
  logic [mrt_pkg::ADDR_W-1:0]  addr;
  logic [mrt_pkg::START_W-1:0] va;
  logic                        wf;
  logic                        early;
  logic [mrt_pkg::STAT_W-1:0]  early_status;
  mrt_pkg::mrt_entry_t         new_entry;
  logic [IW-1:0]               rd_idx;
  logic                        issue_done;
  logic                        ev_vld;
  logic [IW-1:0]               ev_idx;
  logic                        ev_last;
  logic                        found;
  logic [IW-1:0]               hit_idx;
  mrt_pkg::mrt_entry_t         hit_entry;
  logic [mrt_pkg::CNT_W-1:0]   removed;

  logic [mrt_pkg::STAT_W-1:0]  chk_status;
  logic [mrt_pkg::PID_W-1:0]   rd_owner;
  mrt_pkg::mrt_entry_t         rd_entry;
  logic [IW-1:0]               wr_idx;
  mrt_pkg::mrt_wr_t            wr;
  logic                        issuing;
  logic                        own;
  logic                        hit;
  logic [mrt_pkg::START_W:0]   region_end;
  logic                        out_free;
  logic                        accept;

  logic [mrt_pkg::STAT_W-1:0]  status_next;
  logic [mrt_pkg::START_W-1:0] region_next;
  logic [mrt_pkg::SLOT_W-1:0]  slot_next;
  logic [mrt_pkg::OFS_W-1:0]   pofs_next;
  logic                        anon_next;
  logic                        writable_next;
  logic [mrt_pkg::CNT_W-1:0]   removed_next;

  mrt_check #(.PAGE_BYTES(PAGE_BYTES), .OPEN_FILES(OPEN_FILES)) u_check (
    .address     (req.address),
    .length      (req.length),
    .prot        (req.prot),
    .flags       (req.flags),
    .fd          (req.fd),
    .src_offset  (req.src_offset),
    .file_access (req.file_access),
    .status      (chk_status)
  );

  mrt_store #(.TABLE_SLOTS(TABLE_SLOTS), .IW(IW)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_owner (rd_owner),
    .rd_entry (rd_entry),
    .wr_idx   (wr_idx),
    .wr       (wr)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign issuing   = (state == S_SCAN) && !issue_done;

  // evaluate the slot read in the previous cycle
  assign own        = (pid != '0) && (rd_owner == pid);
  assign region_end = {1'b0, rd_entry.start} + (mrt_pkg::START_W + 1)'(rd_entry.length);
  always_comb begin
    case (act)
      mrt_pkg::ACT_MAP:   hit = (rd_owner == '0);
      mrt_pkg::ACT_UNMAP: hit = own && (rd_entry.start == {1'b0, addr});
      mrt_pkg::ACT_FAULT: hit = own && (rd_entry.start <= va) &&
                                ({1'b0, va} < region_end);
      default:            hit = 1'b0;
    endcase
  end

  // release clears owned slots on the fly; map and unmap write when the scan ends
  always_comb begin
    wr        = '0;
    wr.entry  = new_entry;
    wr_idx    = hit_idx;
    if (state == S_SCAN && ev_vld && act == mrt_pkg::ACT_RELEASE && own) begin
      wr.en  = 1'b1;
      wr_idx = ev_idx;
    end else if (state == S_DONE && out_free && !early && found) begin
      if (act == mrt_pkg::ACT_MAP) begin
        wr.en      = 1'b1;
        wr.data_en = 1'b1;
        wr.owner   = pid;
      end else if (act == mrt_pkg::ACT_UNMAP) begin
        wr.en = 1'b1;
      end
    end
  end

  // result beat for the finished request
  always_comb begin
    status_next   = mrt_pkg::ST_OK;
    region_next   = '0;
    slot_next     = '0;
    pofs_next     = '0;
    anon_next     = 1'b0;
    writable_next = 1'b0;
    removed_next  = '0;
    if (early) begin
      status_next = early_status;
    end else begin
      case (act)
        mrt_pkg::ACT_MAP: begin
          if (found) begin
            region_next = new_entry.start;
            slot_next   = mrt_pkg::SLOT_W'(hit_idx);
          end else begin
            status_next = mrt_pkg::ST_FULL;
          end
        end
        mrt_pkg::ACT_UNMAP: begin
          if (found) slot_next = mrt_pkg::SLOT_W'(hit_idx);
          else status_next = mrt_pkg::ST_NOT_FOUND;
        end
        mrt_pkg::ACT_FAULT: begin
          if (!found) begin
            status_next = mrt_pkg::ST_NOT_FOUND;
          end else if (wf && !hit_entry.writable) begin
            status_next = mrt_pkg::ST_DENIED;
          end else begin
            region_next   = va;
            slot_next     = mrt_pkg::SLOT_W'(hit_idx);
            pofs_next     = hit_entry.src_offset +
                            mrt_pkg::OFS_W'(va - hit_entry.start);
            anon_next     = hit_entry.anonymous;
            writable_next = hit_entry.writable;
          end
        end
        default: removed_next = removed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_base <= mrt_pkg::MAP_BASE_RST;
    end else if (cfg_wr_en) begin
      map_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ev_vld    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      ev_vld <= issuing;
      if (state == S_DONE && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            act          <= req.action;
            pid          <= req.process_id;
            addr         <= req.address;
            va           <= {1'b0, req.address[mrt_pkg::ADDR_W-1:PB], {PB{1'b0}}};
            wf           <= req.store_fault;
            new_entry.start       <= mrt_pkg::START_W'({1'b0, map_base} +
                                                       {1'b0, req.address});
            new_entry.length      <= req.length[mrt_pkg::SLEN_W-1:0];
            new_entry.src_offset  <= req.src_offset;
            new_entry.writable    <= req.prot[1];
            new_entry.anonymous   <= req.flags[0];
            rd_idx       <= '0;
            issue_done   <= 1'b0;
            found        <= 1'b0;
            removed      <= '0;
            if (req.action == mrt_pkg::ACT_MAP && chk_status != mrt_pkg::ST_OK) begin
              early        <= 1'b1;
              early_status <= chk_status;
              state        <= S_DONE;
            end else if (req.action == mrt_pkg::ACT_MAP && req.process_id == '0) begin
              early        <= 1'b1;
              early_status <= mrt_pkg::ST_FULL;
              state        <= S_DONE;
            end else if (req.action == mrt_pkg::ACT_UNMAP &&
                         req.address[PB-1:0] != '0) begin
              early        <= 1'b1;
              early_status <= mrt_pkg::ST_MISALIGNED;
              state        <= S_DONE;
            end else begin
              early        <= 1'b0;
              early_status <= mrt_pkg::ST_OK;
              state        <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            if (rd_idx == IW'(TABLE_SLOTS - 1)) issue_done <= 1'b1;
            else rd_idx <= rd_idx + 1'b1;
          end
          ev_idx  <= rd_idx;
          ev_last <= (rd_idx == IW'(TABLE_SLOTS - 1));
          if (ev_vld) begin
            if (act == mrt_pkg::ACT_RELEASE && own) removed <= removed + 1'b1;
            if (hit) begin
              found     <= 1'b1;
              hit_idx   <= ev_idx;
              hit_entry <= rd_entry;
            end
            if (hit || ev_last) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.status           <= status_next;
            rsp.region_address   <= region_next;
            rsp.slot             <= slot_next;
            rsp.page_file_offset <= pofs_next;
            rsp.is_anonymous     <= anon_next;
            rsp.is_writable      <= writable_next;
            rsp.removed_count    <= removed_next;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/mrt_check.sv
// Argument checks for a map request, in priority order.
// Depends on mrt_pkg for status codes and widths.
module mrt_check #(
  parameter int PAGE_BYTES = mrt_pkg::PAGE_BYTES_DEF,
  parameter int OPEN_FILES = mrt_pkg::OPEN_FILES_DEF
) (
  input  logic [mrt_pkg::ADDR_W-1:0]        address,
  input  logic signed [mrt_pkg::LEN_W-1:0]  length,
  input  logic [1:0]                        prot,
  input  logic [1:0]                        flags,
  input  logic signed [mrt_pkg::FD_W-1:0]   fd,
  input  logic signed [mrt_pkg::OFS_W-1:0]  src_offset,
  input  logic [2:0]                        file_access,
  output logic [mrt_pkg::STAT_W-1:0]        status
);
  localparam int PB = $clog2(PAGE_BYTES);

  logic fd_bad;

  // fd is negative or not below the open file count
  assign fd_bad = fd[mrt_pkg::FD_W-1] ||
                  ({2'b00, fd[mrt_pkg::FD_W-2:0]} >= 7'(OPEN_FILES));

  always_comb begin
    status = mrt_pkg::ST_OK;
    if (address[PB-1:0] != '0) begin
      status = mrt_pkg::ST_MISALIGNED;
    end else if (length <= 0 || length[PB-1:0] != '0) begin
      status = mrt_pkg::ST_BAD_LENGTH;
    end else if (prot != 2'd1 && prot != 2'd3) begin
      status = mrt_pkg::ST_BAD_PROT;
    end else if (flags[1]) begin
      status = mrt_pkg::ST_BAD_FLAGS;
    end else if (flags[0]) begin
      if (fd != -6'sd1 || src_offset != '0) status = mrt_pkg::ST_BAD_FILE;
    end else begin
      if (fd_bad || !file_access[0] || (prot[0] && !file_access[1]) ||
          (prot[1] && !file_access[2])) begin
        status = mrt_pkg::ST_BAD_FILE;
      end
    end
  end
endmodule

### rtl/mrt_store.sv
// Slot memories: owner with per-slot valid bits, and region data.
// One read and one write port, read data registered. Depends on mrt_pkg.
module mrt_store #(
  parameter int TABLE_SLOTS = mrt_pkg::TABLE_SLOTS_DEF,
  parameter int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [IW-1:0]              rd_idx,
  output logic [mrt_pkg::PID_W-1:0]  rd_owner,
  output mrt_pkg::mrt_entry_t        rd_entry,
  input  logic [IW-1:0]              wr_idx,
  input  mrt_pkg::mrt_wr_t           wr
);
  logic [mrt_pkg::PID_W-1:0] owner_mem [TABLE_SLOTS];
  mrt_pkg::mrt_entry_t       data_mem  [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]    owner_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid <= '0;
    end else if (wr.en) begin
      owner_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) owner_mem[wr_idx] <= wr.owner;
    if (wr.data_en) data_mem[wr_idx] <= wr.entry;
    rd_owner <= owner_valid[rd_idx] ? owner_mem[rd_idx] : '0;
    rd_entry <= data_mem[rd_idx];
  end
endmodule

### rtl/mrt_checker.sv
// Port-level assertions for the mapped region table, bound to the top level.
// Depends on mrt_pkg for status codes.
module mrt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [mrt_pkg::STAT_W-1:0]        rsp_status,
  input logic [mrt_pkg::START_W-1:0]       rsp_region_address,
  input logic [mrt_pkg::OFS_W-1:0]         rsp_page_file_offset,
  input logic [mrt_pkg::CNT_W-1:0]         rsp_removed_count
);
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("stalled response beat changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status <= mrt_pkg::ST_DENIED)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != mrt_pkg::ST_OK |->
      rsp_region_address == '0 && rsp_page_file_offset == '0 && rsp_removed_count == '0)
    else $error("failed response carries nonzero fields");
endmodule

bind mmap_region_table mrt_checker u_mrt_checker (
  .clk                  (clk),
  .rst                  (rst),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_status           (rsp.status),
  .rsp_region_address   (rsp.region_address),
  .rsp_page_file_offset (rsp.page_file_offset),
  .rsp_removed_count    (rsp.removed_count)
);
